// ===== design/buddy_block_allocator_defines.svh =====
// assertion macros for the buddy block allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bba_pkg.sv =====
// shared types and codes for the buddy block allocator
`default_nettype none
package bba_pkg;

    // node state codes
    localparam logic [1:0] NS_ABSENT = 2'd0;
    localparam logic [1:0] NS_FREE   = 2'd1;
    localparam logic [1:0] NS_SPLIT  = 2'd2;
    localparam logic [1:0] NS_ALLOC  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OOM     = 3'd1;
    localparam logic [2:0] ST_ZERO    = 3'd2;
    localparam logic [2:0] ST_LARGE   = 3'd3;
    localparam logic [2:0] ST_BADFREE = 3'd4;

    localparam logic [7:0] HEADER_RESET = 8'd24;

    typedef logic [4:0] dp_op_t;

    localparam dp_op_t OP_NONE          = 5'd0;
    localparam dp_op_t OP_CLR           = 5'd1;
    localparam dp_op_t OP_LOAD          = 5'd2;
    localparam dp_op_t OP_SCAN_INIT     = 5'd3;
    localparam dp_op_t OP_SCAN_RD       = 5'd4;
    localparam dp_op_t OP_SCAN_NEXT_K   = 5'd5;
    localparam dp_op_t OP_SCAN_NEXT_ORD = 5'd6;
    localparam dp_op_t OP_FOUND         = 5'd7;
    localparam dp_op_t OP_WR_SPLIT      = 5'd8;
    localparam dp_op_t OP_WR_RIGHT      = 5'd9;
    localparam dp_op_t OP_WR_ALLOC      = 5'd10;
    localparam dp_op_t OP_FD_INIT       = 5'd11;
    localparam dp_op_t OP_FD_RD         = 5'd12;
    localparam dp_op_t OP_FD_STEP       = 5'd13;
    localparam dp_op_t OP_FD_HIT        = 5'd14;
    localparam dp_op_t OP_MG_RD         = 5'd15;
    localparam dp_op_t OP_MG_WN         = 5'd16;
    localparam dp_op_t OP_MG_WB         = 5'd17;
    localparam dp_op_t OP_MG_UP         = 5'd18;
    localparam dp_op_t OP_RES_FREE      = 5'd19;
    localparam dp_op_t OP_RES_ERR       = 5'd20;
    localparam dp_op_t OP_OUT_LOAD      = 5'd21;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] err;
    } dp_cmd_t;

    typedef struct packed {
        logic       cmd_free;
        logic       req_zero;
        logic       too_large;
        logic       off_bad;
        logic       clear_last;
        logic       k_last;
        logic       ord_max;
        logic       ord_gt_tgt;
        logic       off_match;
        logic       fd_right;
        logic       fd_leaf;
        logic       n_root;
        logic [1:0] rdata;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/bba_dp.sv =====
// datapath: node memory, walk registers, result and output registers
`default_nettype none
module bba_dp #(
    parameter int MAX_ORDER       = 10,
    parameter int MIN_BLOCK_BYTES = 32
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_we,
    input  wire  [7:0]         cfg_wdata,
    input  wire                in_cmd,
    input  wire  [15:0]        in_req,
    input  wire  [14:0]        in_off,
    input  bba_pkg::dp_cmd_t   cmd,
    output bba_pkg::dp_stat_t  stat,
    output logic [14:0]        out_off,
    output logic [3:0]         out_ord,
    output logic [2:0]         out_st
);
    localparam int IW      = MAX_ORDER + 1;
    localparam int NODES   = (2 << MAX_ORDER) - 1;
    localparam int KW      = MAX_ORDER;
    localparam int TW      = $clog2(MAX_ORDER + 2);
    localparam int MIN_LOG = $clog2(MIN_BLOCK_BYTES);
    localparam int OFW     = (MIN_LOG + MAX_ORDER + 1 > 16) ? MIN_LOG + MAX_ORDER + 1 : 16;
    localparam logic [OFW-1:0] POOL = OFW'(MIN_BLOCK_BYTES) << MAX_ORDER;

    logic [1:0]     mem [NODES];
    logic [1:0]     rdata_reg;
    logic [7:0]     hdr_reg;
    logic [IW-1:0]  clr_reg;
    logic           cmd_free_reg;
    logic           req_zero_reg;
    logic [TW-1:0]  tgt_reg;
    logic [OFW-1:0] off_reg;
    logic [OFW-1:0] noff_reg;
    logic [TW-1:0]  ord_reg;
    logic [KW-1:0]  k_reg;
    logic [IW-1:0]  n_reg;
    logic [TW-1:0]  gord_reg;
    logic [14:0]    res_off_reg;
    logic [3:0]     res_ord_reg;
    logic [2:0]     res_st_reg;
    logic [14:0]    out_off_reg;
    logic [3:0]     out_ord_reg;
    logic [2:0]     out_st_reg;

    logic [16:0]    total;
    logic [TW-1:0]  tgt_c;
    logic [IW-1:0]  first_c;
    logic [IW-1:0]  scan_node;
    logic [OFW-1:0] scan_off;
    logic [OFW-1:0] half;
    logic [IW-1:0]  left_c;
    logic [IW-1:0]  right_c;
    logic [IW-1:0]  buddy_c;
    logic [IW-1:0]  parent_c;
    logic           we;
    logic [IW-1:0]  waddr;
    logic [1:0]     wdata;
    logic           re;
    logic [IW-1:0]  raddr;

    // smallest order whose block holds request plus header
    always_comb begin
        total = 17'(in_req) + 17'(hdr_reg);
        tgt_c = TW'(MAX_ORDER + 1);
        for (int o = MAX_ORDER; o >= 0; o--) begin
            if ((32'(MIN_BLOCK_BYTES) << o) >= 32'(total)) begin
                tgt_c = TW'(o);
            end
        end
    end

    assign first_c   = (IW'(1) << (MAX_ORDER - int'(ord_reg))) - IW'(1);
    assign scan_node = first_c + IW'(k_reg);
    assign scan_off  = OFW'(k_reg) << (MIN_LOG + int'(ord_reg));
    assign half      = OFW'(1) << (MIN_LOG + int'(ord_reg) - 1);
    assign left_c    = {n_reg[IW-2:0], 1'b0} + IW'(1);
    assign right_c   = {n_reg[IW-2:0], 1'b0} + IW'(2);
    assign buddy_c   = n_reg[0] ? n_reg + IW'(1) : n_reg - IW'(1);
    assign parent_c  = (n_reg - IW'(1)) >> 1;

    always_comb begin
        stat.cmd_free   = cmd_free_reg;
        stat.req_zero   = req_zero_reg;
        stat.too_large  = (tgt_reg > TW'(MAX_ORDER));
        stat.off_bad    = (off_reg >= POOL);
        stat.clear_last = (clr_reg == IW'(NODES - 1));
        stat.k_last     = (IW'(k_reg) == first_c);
        stat.ord_max    = (ord_reg == TW'(MAX_ORDER));
        stat.ord_gt_tgt = (ord_reg > tgt_reg);
        stat.off_match  = (off_reg == noff_reg);
        stat.fd_right   = (off_reg >= noff_reg + half);
        stat.fd_leaf    = (ord_reg == '0);
        stat.n_root     = (n_reg == '0);
        stat.rdata      = rdata_reg;
    end

    always_comb begin
        we    = 1'b0;
        waddr = n_reg;
        wdata = bba_pkg::NS_ABSENT;
        re    = 1'b0;
        raddr = n_reg;
        unique case (cmd.op)
            bba_pkg::OP_CLR: begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = (clr_reg == '0) ? bba_pkg::NS_FREE : bba_pkg::NS_ABSENT;
            end
            bba_pkg::OP_SCAN_RD: begin
                re    = 1'b1;
                raddr = scan_node;
            end
            bba_pkg::OP_WR_SPLIT: begin
                we    = 1'b1;
                wdata = bba_pkg::NS_SPLIT;
            end
            bba_pkg::OP_WR_RIGHT: begin
                we    = 1'b1;
                waddr = right_c;
                wdata = bba_pkg::NS_FREE;
            end
            bba_pkg::OP_WR_ALLOC: begin
                we    = 1'b1;
                wdata = bba_pkg::NS_ALLOC;
            end
            bba_pkg::OP_FD_RD: begin
                re = 1'b1;
            end
            bba_pkg::OP_FD_HIT: begin
                we    = 1'b1;
                wdata = bba_pkg::NS_FREE;
            end
            bba_pkg::OP_MG_RD: begin
                re    = 1'b1;
                raddr = buddy_c;
            end
            bba_pkg::OP_MG_WN: begin
                we = 1'b1;
            end
            bba_pkg::OP_MG_WB: begin
                we    = 1'b1;
                waddr = buddy_c;
            end
            bba_pkg::OP_MG_UP: begin
                we    = 1'b1;
                waddr = parent_c;
                wdata = bba_pkg::NS_FREE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg <= bba_pkg::HEADER_RESET;
            clr_reg <= '0;
        end else begin
            if (cfg_we) begin
                hdr_reg <= cfg_wdata;
            end
            if (cmd.op == bba_pkg::OP_CLR) begin
                clr_reg <= clr_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            bba_pkg::OP_LOAD: begin
                cmd_free_reg <= in_cmd;
                req_zero_reg <= (in_req == '0);
                tgt_reg      <= tgt_c;
                off_reg      <= OFW'(in_off);
            end
            bba_pkg::OP_SCAN_INIT: begin
                ord_reg <= tgt_reg;
                k_reg   <= '0;
            end
            bba_pkg::OP_SCAN_NEXT_K: begin
                k_reg <= k_reg + KW'(1);
            end
            bba_pkg::OP_SCAN_NEXT_ORD: begin
                ord_reg <= ord_reg + TW'(1);
                k_reg   <= '0;
            end
            bba_pkg::OP_FOUND: begin
                n_reg   <= scan_node;
                off_reg <= scan_off;
            end
            bba_pkg::OP_WR_RIGHT: begin
                n_reg   <= left_c;
                ord_reg <= ord_reg - TW'(1);
            end
            bba_pkg::OP_WR_ALLOC: begin
                res_off_reg <= off_reg[14:0];
                res_ord_reg <= 4'(tgt_reg);
                res_st_reg  <= bba_pkg::ST_OK;
            end
            bba_pkg::OP_FD_INIT: begin
                n_reg    <= '0;
                noff_reg <= '0;
                ord_reg  <= TW'(MAX_ORDER);
            end
            bba_pkg::OP_FD_STEP: begin
                if (stat.fd_right) begin
                    n_reg    <= right_c;
                    noff_reg <= noff_reg + half;
                end else begin
                    n_reg <= left_c;
                end
                ord_reg <= ord_reg - TW'(1);
            end
            bba_pkg::OP_FD_HIT: begin
                gord_reg <= ord_reg;
            end
            bba_pkg::OP_MG_UP: begin
                n_reg <= parent_c;
            end
            bba_pkg::OP_RES_FREE: begin
                res_off_reg <= off_reg[14:0];
                res_ord_reg <= 4'(gord_reg);
                res_st_reg  <= bba_pkg::ST_OK;
            end
            bba_pkg::OP_RES_ERR: begin
                res_off_reg <= '0;
                res_ord_reg <= '0;
                res_st_reg  <= cmd.err;
            end
            bba_pkg::OP_OUT_LOAD: begin
                out_off_reg <= res_off_reg;
                out_ord_reg <= res_ord_reg;
                out_st_reg  <= res_st_reg;
            end
            default: begin
            end
        endcase
    end

    assign out_off = out_off_reg;
    assign out_ord = out_ord_reg;
    assign out_st  = out_st_reg;

endmodule
`default_nettype wire

// ===== design/bba_ctrl.sv =====
// controller state machine sequencing the datapath
`default_nettype none
module bba_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire                m_tready,
    input  bba_pkg::dp_stat_t  stat,
    output bba_pkg::dp_cmd_t   cmd
);
    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECODE  = 4'd2;
    localparam logic [3:0] S_SCAN_RD = 4'd3;
    localparam logic [3:0] S_SCAN_EV = 4'd4;
    localparam logic [3:0] S_SPLIT   = 4'd5;
    localparam logic [3:0] S_SPLIT2  = 4'd6;
    localparam logic [3:0] S_FD_RD   = 4'd7;
    localparam logic [3:0] S_FD_EV   = 4'd8;
    localparam logic [3:0] S_MG_RD   = 4'd9;
    localparam logic [3:0] S_MG_EV   = 4'd10;
    localparam logic [3:0] S_MG_WB   = 4'd11;
    localparam logic [3:0] S_MG_UP   = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    always_comb begin
        state_next = state_reg;
        cmd.op     = bba_pkg::OP_NONE;
        cmd.err    = bba_pkg::ST_OK;
        valid_next = (valid_reg && m_tready) ? 1'b0 : valid_reg;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.op = bba_pkg::OP_CLR;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = bba_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (stat.cmd_free && stat.off_bad) begin
                    cmd.op     = bba_pkg::OP_RES_ERR;
                    cmd.err    = bba_pkg::ST_BADFREE;
                    state_next = S_DONE;
                end else if (stat.cmd_free) begin
                    cmd.op     = bba_pkg::OP_FD_INIT;
                    state_next = S_FD_RD;
                end else if (stat.req_zero) begin
                    cmd.op     = bba_pkg::OP_RES_ERR;
                    cmd.err    = bba_pkg::ST_ZERO;
                    state_next = S_DONE;
                end else if (stat.too_large) begin
                    cmd.op     = bba_pkg::OP_RES_ERR;
                    cmd.err    = bba_pkg::ST_LARGE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = bba_pkg::OP_SCAN_INIT;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                cmd.op     = bba_pkg::OP_SCAN_RD;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                priority if (stat.rdata == bba_pkg::NS_FREE) begin
                    cmd.op     = bba_pkg::OP_FOUND;
                    state_next = S_SPLIT;
                end else if (!stat.k_last) begin
                    cmd.op     = bba_pkg::OP_SCAN_NEXT_K;
                    state_next = S_SCAN_RD;
                end else if (!stat.ord_max) begin
                    cmd.op     = bba_pkg::OP_SCAN_NEXT_ORD;
                    state_next = S_SCAN_RD;
                end else begin
                    cmd.op     = bba_pkg::OP_RES_ERR;
                    cmd.err    = bba_pkg::ST_OOM;
                    state_next = S_DONE;
                end
            end
            S_SPLIT: begin
                if (stat.ord_gt_tgt) begin
                    cmd.op     = bba_pkg::OP_WR_SPLIT;
                    state_next = S_SPLIT2;
                end else begin
                    cmd.op     = bba_pkg::OP_WR_ALLOC;
                    state_next = S_DONE;
                end
            end
            S_SPLIT2: begin
                cmd.op     = bba_pkg::OP_WR_RIGHT;
                state_next = S_SPLIT;
            end
            S_FD_RD: begin
                cmd.op     = bba_pkg::OP_FD_RD;
                state_next = S_FD_EV;
            end
            S_FD_EV: begin
                priority if (stat.rdata == bba_pkg::NS_ALLOC && stat.off_match) begin
                    cmd.op     = bba_pkg::OP_FD_HIT;
                    state_next = S_MG_RD;
                end else if (stat.rdata != bba_pkg::NS_SPLIT || stat.fd_leaf) begin
                    cmd.op     = bba_pkg::OP_RES_ERR;
                    cmd.err    = bba_pkg::ST_BADFREE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = bba_pkg::OP_FD_STEP;
                    state_next = S_FD_RD;
                end
            end
            S_MG_RD: begin
                if (stat.n_root) begin
                    cmd.op     = bba_pkg::OP_RES_FREE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = bba_pkg::OP_MG_RD;
                    state_next = S_MG_EV;
                end
            end
            S_MG_EV: begin
                if (stat.rdata != bba_pkg::NS_FREE) begin
                    cmd.op     = bba_pkg::OP_RES_FREE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = bba_pkg::OP_MG_WN;
                    state_next = S_MG_WB;
                end
            end
            S_MG_WB: begin
                cmd.op     = bba_pkg::OP_MG_WB;
                state_next = S_MG_UP;
            end
            S_MG_UP: begin
                cmd.op     = bba_pkg::OP_MG_UP;
                state_next = S_MG_RD;
            end
            S_DONE: begin
                // wait for the output register to drain
                if (!valid_reg || m_tready) begin
                    cmd.op     = bba_pkg::OP_OUT_LOAD;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

endmodule
`default_nettype wire

// ===== design/buddy_block_allocator.sv =====
// top level of the buddy block allocator
//
//  port group   direction  tdata / tuser contents
//  s_*          in         tuser: command; tdata: request_bytes, block_offset
//  m_*          out        tdata: granted_offset, granted_order, status
//  cfg_*        in         header_bytes write
//
// allocate: nodes are read and evaluated one at a time (lowest order first), then split one level at a time
// free: walks down one level at a time, then merges with free buddies going up
// each transaction also passes through decode and output handoff
// after reset a clearing pass writes every node before s_tready rises
// a finished result waits in the output register while the next transaction is taken
`default_nettype none
`include "buddy_block_allocator_defines.svh"
module buddy_block_allocator #(
    parameter int MAX_ORDER       = 10,
    parameter int MIN_BLOCK_BYTES = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [7:0]  cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,  // request_bytes[15:0], block_offset[30:16]
    input  wire         s_tuser,  // command
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata   // granted_offset[14:0], granted_order[18:15], status[21:19]
);
    bba_pkg::dp_cmd_t  cmd;
    bba_pkg::dp_stat_t stat;
    logic [14:0]       out_off;
    logic [3:0]        out_ord;
    logic [2:0]        out_st;

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_dp #(
        .MAX_ORDER       (MAX_ORDER),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_cmd    (s_tuser),
        .in_req    (s_tdata[15:0]),
        .in_off    (s_tdata[30:16]),
        .cmd       (cmd),
        .stat      (stat),
        .out_off   (out_off),
        .out_ord   (out_ord),
        .out_st    (out_st)
    );

    assign m_tdata = {2'b00, out_st, out_ord, out_off};

    `BBA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "took a second item while busy")
    `BBA_ASSERT_NOW(a_status_range, m_tvalid, m_tdata[21:19] <= bba_pkg::ST_BADFREE, "status out of range")
    `BBA_ASSERT_NOW(a_error_zeroed, m_tvalid && m_tdata[21:19] != bba_pkg::ST_OK, m_tdata[18:0] == 19'd0, "error result not zeroed")

endmodule
`default_nettype wire

// ===== dv/buddy_block_allocator_tb.sv =====
// testbench for the buddy block allocator: random and directed commands checked against a tree model
`default_nettype none
module buddy_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ORDERS = 10;
    localparam int NODES  = (2 << ORDERS) - 1;
    localparam int POOL   = 32 << ORDERS;
    localparam bit CMD_ALLOC = 1'b0;
    localparam bit CMD_FREE  = 1'b1;

    // packed lowest field last so it lines up with m_tdata
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  order;
        logic [14:0] offset;
    } grant_t;

    class grant_scoreboard;
        logic [1:0] tree [NODES];
        logic [7:0] header;
        grant_t     pending_grants [$];
        int         live_blocks [$];
        int         errors;

        function new();
            foreach (tree[i]) tree[i] = bba_pkg::NS_ABSENT;
            tree[0] = bba_pkg::NS_FREE;
            header = bba_pkg::HEADER_RESET;
            errors = 0;
        endfunction

        function int base_of(int n, int d);
            return (n - ((1 << d) - 1)) * (32 << (ORDERS - d));
        endfunction

        function grant_t allocate(int req);
            grant_t g;
            int total, tgt, n, d;
            bit found;
            g = '0;
            total = req + header;
            tgt = 0;
            found = 0;
            n = 0;
            if (req == 0) begin
                g.status = bba_pkg::ST_ZERO;
                return g;
            end
            while (tgt <= ORDERS && (32 << tgt) < total) tgt++;
            if (tgt > ORDERS) begin
                g.status = bba_pkg::ST_LARGE;
                return g;
            end
            for (int o = tgt; o <= ORDERS && !found; o++) begin
                d = ORDERS - o;
                for (int k = 0; k < (1 << d); k++) begin
                    if (tree[(1 << d) - 1 + k] == bba_pkg::NS_FREE) begin
                        n = (1 << d) - 1 + k;
                        found = 1;
                        break;
                    end
                end
            end
            if (!found) begin
                g.status = bba_pkg::ST_OOM;
                return g;
            end
            d = 0;
            while (((2 << d) - 1) <= n) d++;
            while (ORDERS - d > tgt) begin
                tree[n] = bba_pkg::NS_SPLIT;
                tree[2 * n + 2] = bba_pkg::NS_FREE;
                n = 2 * n + 1;
                d++;
            end
            tree[n] = bba_pkg::NS_ALLOC;
            g.offset = 15'(base_of(n, d));
            g.order = 4'(tgt);
            g.status = bba_pkg::ST_OK;
            live_blocks.push_back(base_of(n, d));
            return g;
        endfunction

        function grant_t release_block(int off);
            grant_t g;
            int n, d, buddy;
            g = '0;
            g.status = bba_pkg::ST_BADFREE;
            n = 0;
            d = 0;
            if (off >= POOL) return g;
            forever begin
                if (tree[n] == bba_pkg::NS_ALLOC) begin
                    if (off != base_of(n, d)) return g;
                    break;
                end
                if (tree[n] != bba_pkg::NS_SPLIT || d >= ORDERS) return g;
                if (off >= base_of(n, d) + (32 << (ORDERS - d - 1))) n = 2 * n + 2;
                else n = 2 * n + 1;
                d++;
            end
            g.offset = 15'(off);
            g.order = 4'(ORDERS - d);
            g.status = bba_pkg::ST_OK;
            tree[n] = bba_pkg::NS_FREE;
            while (n > 0) begin
                buddy = n[0] ? n + 1 : n - 1;
                if (tree[buddy] != bba_pkg::NS_FREE) break;
                tree[n] = bba_pkg::NS_ABSENT;
                tree[buddy] = bba_pkg::NS_ABSENT;
                n = (n - 1) / 2;
                tree[n] = bba_pkg::NS_FREE;
            end
            foreach (live_blocks[i]) begin
                if (live_blocks[i] == off) begin
                    live_blocks.delete(i);
                    break;
                end
            end
            return g;
        endfunction

        function void note_command(bit cmd, int req, int off);
            pending_grants.push_back(cmd == CMD_FREE ? release_block(off) : allocate(req));
        endfunction

        function void check_grant(grant_t got);
            grant_t exp;
            if (pending_grants.size() == 0) begin
                $error("unexpected result transaction %h", got);
                errors++;
                return;
            end
            exp = pending_grants.pop_front();
            if (got.offset !== exp.offset) begin
                $error("granted_offset: expected %0d, actual %0d", exp.offset, got.offset);
                errors++;
            end
            if (got.order !== exp.order) begin
                $error("granted_order: expected %0d, actual %0d", exp.order, got.order);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    grant_scoreboard sb;
    bit steady;
    int ready_hold;

    buddy_block_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #400ms;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_command(bit cmd, int req, int off);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, off[14:0], req[15:0]};
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, req, off);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_grants.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_header(logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.header = value;
    endtask

    task automatic random_command();
        int pick, req;
        pick = $urandom_range(0, 99);
        if (pick >= 50 && pick < 90 && sb.live_blocks.size() > 0) begin
            send_command(CMD_FREE, 0,
                sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)]);
        end else if (pick >= 90) begin
            if (pick < 95 || sb.live_blocks.size() == 0)
                send_command(CMD_FREE, $urandom_range(0, 65535), $urandom_range(0, 32767));
            else
                // near a live block: at its start, inside it, or past its end
                send_command(CMD_FREE, 0, (sb.live_blocks[0] + 32 * $urandom_range(0, 3))
                    % POOL);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) req = $urandom_range(1, 200);
            else if (pick < 90) req = $urandom_range(1, 4000);
            else if (pick < 97) req = $urandom_range(1, 32768);
            else req = $urandom_range(0, 65535);
            send_command(CMD_ALLOC, req, $urandom_range(0, 32767));
        end
    endtask

    // result side: random stalls after each transaction, none while steady
    initial begin
        m_tready = 1'b0;
        ready_hold = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_grant(m_tdata[21:0]);
                ready_hold = steady ? 0 : $urandom_range(0, 5);
            end
            if (ready_hold > 0) begin
                m_tready <= 1'b0;
                ready_hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [7:0] headers [4];
        sb = new();
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 8'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 32'd0;
        s_tuser   = 1'b0;
        steady    = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero, oversize, exact fit of the pool, splits, bad frees, merges
        send_command(CMD_ALLOC, 0, 0);
        send_command(CMD_ALLOC, 65535, 32767);
        send_command(CMD_ALLOC, 32744, 0);
        send_command(CMD_ALLOC, 1, 0);
        send_command(CMD_FREE, 0, 0);
        send_command(CMD_ALLOC, 32745, 0);
        send_command(CMD_ALLOC, 1, 0);
        send_command(CMD_ALLOC, 8, 0);
        send_command(CMD_ALLOC, 9, 0);
        send_command(CMD_FREE, 0, 96);
        send_command(CMD_FREE, 0, 64);
        send_command(CMD_FREE, 0, 64);
        send_command(CMD_FREE, 0, 20000);
        send_command(CMD_FREE, 0, 32767);
        send_command(CMD_ALLOC, 16000, 0);
        send_command(CMD_ALLOC, 16000, 0);
        send_command(CMD_ALLOC, 1, 0);
        send_command(CMD_FREE, 0, 0);
        send_command(CMD_FREE, 0, 32);
        send_command(CMD_FREE, 0, 16384);
        send_command(CMD_FREE, 0, 32768 - 1 - 16384);
        drain();

        headers[0] = 8'd0;
        headers[1] = 8'd255;
        headers[2] = bba_pkg::HEADER_RESET;
        headers[3] = 8'($urandom_range(0, 255));
        foreach (headers[p]) begin
            write_header(headers[p]);
            for (int i = 0; i < 320; i++) begin
                if (i % 80 == 0) steady = ($urandom_range(0, 3) == 0);
                random_command();
            end
            steady = 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.pending_grants.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/bba_pkg.sv
design/bba_dp.sv
design/bba_ctrl.sv
design/buddy_block_allocator.sv
dv/buddy_block_allocator_tb.sv
